// ===== hw/rtl/stack_arena_allocator_unit_macros.svh =====
// Assertion helpers shared by the RTL; the asserting module provides clk and arst_n.
`ifndef STACK_ARENA_ALLOCATOR_UNIT_MACROS_SVH
`define STACK_ARENA_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define SAA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SAA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/saa_pkg.sv =====
package saa_pkg;

	localparam int SIZE_W     = 16;
	localparam int OFFSET_W   = 15;
	localparam int STATUS_W   = 2;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [APB_ADDR_W-3:0] REG_LIMIT_BYTES = '0;
	localparam logic [SIZE_W-1:0]     LIMIT_RESET     = 16'd32768;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK,
		STATUS_NOMEM,
		STATUS_NOT_ALLOC
	} status_t;

endpackage

// ===== hw/rtl/saa_in_if.sv =====
interface saa_in_if;
	logic                            valid;
	logic                            ready;
	logic                            command;
	logic [saa_pkg::SIZE_W-1:0]      size_bytes;
	logic [saa_pkg::OFFSET_W-1:0]    offset_bytes;

	modport source (output valid, command, size_bytes, offset_bytes, input ready);
	modport sink (input valid, command, size_bytes, offset_bytes, output ready);
endinterface

// ===== hw/rtl/saa_out_if.sv =====
interface saa_out_if;
	logic                            valid;
	logic                            ready;
	logic [saa_pkg::STATUS_W-1:0]    status;
	logic [saa_pkg::OFFSET_W-1:0]    block_offset;
	logic [saa_pkg::SIZE_W-1:0]      in_use_bytes;
	logic [saa_pkg::SIZE_W-1:0]      footprint_bytes;

	modport source (output valid, status, block_offset, in_use_bytes, footprint_bytes,
		input ready);
	modport sink (input valid, status, block_offset, in_use_bytes, footprint_bytes,
		output ready);
endinterface

// ===== hw/rtl/stack_arena_allocator_unit.sv =====
// Allocate: S_GRAN rounds up to granules, S_SUM and S_CHECK test the fit, S_OUT holds
// the result until taken. Deallocate: S_TCHK checks the trailer, then S_WALK and S_WEVAL
// reclaim one freed block per pass until a live trailer or an empty arena; a rejected
// free answers from S_CHECK or S_TCHK. One request at a time shares the single trailer
// RAM read port and add/sub unit. Reset: asynchronous; a clearing pass then zeroes the
// trailer RAM, input not ready meanwhile; APB writes are taken throughout.
`include "stack_arena_allocator_unit_macros.svh"

module stack_arena_allocator_unit #(
	parameter int ARENA_GRANULES = 4096,
	parameter int GRANULE_BYTES  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	saa_in_if.sink                            in_ch,
	saa_out_if.source                         out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [saa_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [saa_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [saa_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	localparam int SW  = saa_pkg::SIZE_W;
	localparam int OW  = saa_pkg::OFFSET_W;
	localparam int DW  = saa_pkg::APB_DATA_W;
	localparam int GSH = $clog2(GRANULE_BYTES);
	localparam int IW  = $clog2(ARENA_GRANULES);
	localparam int TW  = $clog2(ARENA_GRANULES + 1);
	localparam int EW  = IW + 1;
	localparam int GW  = SW + 1 - GSH;
	localparam int AW  = ((TW > SW) ? TW : SW) + 2;
	localparam int FW  = GW + 1 + GSH;
	localparam int MaxFoot = (2 ** SW) - 1;
	localparam logic [EW-1:0] UsedCode = '1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_GRAN,
		S_SUM,
		S_CHECK,
		S_TCHK,
		S_WALK,
		S_WEVAL,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic                    cmd_q;
	logic [SW-1:0]           size_q;
	logic [OW-1:0]           offset_q;
	logic [GW-1:0]           gran_q;
	logic [AW-1:0]           t_q;
	logic [TW-1:0]           top_q;
	logic [SW-1:0]           limit_q;
	logic [IW-1:0]           clr_addr_q;
	saa_pkg::status_t        status_q;
	logic [OW-1:0]           block_q;
	logic [SW-1:0]           foot_q;

	// shared add/sub unit
	logic [AW-1:0]           alu_a;
	logic [AW-1:0]           alu_b;
	logic                    alu_sub;
	logic [AW-1:0]           alu_y;
	logic                    borrow;

	logic [AW-1:0]           lim_wide;
	logic [AW-1:0]           lim_gran;
	logic [TW+GSH-1:0]       top_bytes;
	logic [FW-1:0]           foot_full;
	logic                    misaligned;

	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	logic [EW-1:0]           mem_wdata;
	logic                    mem_re;
	logic [IW-1:0]           mem_raddr;
	logic [EW-1:0]           mem_rdata;

	logic                    cfg_wr;

	assign lim_wide   = AW'(limit_q >> GSH);
	assign lim_gran   = (lim_wide < AW'(ARENA_GRANULES)) ? lim_wide : AW'(ARENA_GRANULES);
	assign top_bytes  = {top_q, {GSH{1'b0}}};
	assign foot_full  = {(GW + 1)'(gran_q) + (GW + 1)'(1), {GSH{1'b0}}};
	assign misaligned = (offset_q[GSH-1:0] != '0);

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_GRAN: begin
				alu_a = AW'(size_q);
				alu_b = AW'(GRANULE_BYTES - 1);
			end
			S_SUM: begin
				alu_a = (cmd_q == saa_pkg::CMD_FREE) ? AW'(offset_q >> GSH) : AW'(top_q);
				alu_b = AW'(gran_q);
			end
			S_CHECK: begin
				alu_a   = t_q;
				alu_b   = (cmd_q == saa_pkg::CMD_FREE) ? AW'(top_q) : lim_gran;
				alu_sub = 1'b1;
			end
			S_WEVAL: begin
				alu_a   = AW'(top_q);
				alu_b   = AW'(mem_rdata) + AW'(1);
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign alu_y  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
	assign borrow = alu_y[AW-1];

	// trailer RAM port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = t_q[IW-1:0];
		mem_wdata = UsedCode;
		mem_re    = 1'b0;
		mem_raddr = t_q[IW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '0;
			end
			S_CHECK: begin
				mem_re = 1'b1;
				mem_we = (cmd_q == saa_pkg::CMD_ALLOC) && borrow;
			end
			S_TCHK: begin
				mem_we    = (mem_rdata == UsedCode);
				mem_wdata = EW'(gran_q);
			end
			S_WALK: begin
				mem_re    = (top_q != '0);
				mem_raddr = IW'(top_q - TW'(1));
			end
			default: begin
			end
		endcase
	end

	saa_trailer_mem #(
		.DEPTH  (ARENA_GRANULES),
		.DATA_W (EW)
	) u_trailer_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_addr_q <= '0;
			top_q      <= '0;
			cmd_q      <= saa_pkg::CMD_ALLOC;
			size_q     <= '0;
			offset_q   <= '0;
			gran_q     <= '0;
			t_q        <= '0;
			status_q   <= saa_pkg::STATUS_OK;
			block_q    <= '0;
			foot_q     <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + IW'(1);
					if (clr_addr_q == IW'(ARENA_GRANULES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_ch.valid) begin
						cmd_q    <= in_ch.command;
						size_q   <= in_ch.size_bytes;
						offset_q <= in_ch.offset_bytes;
						status_q <= saa_pkg::STATUS_OK;
						block_q  <= '0;
						state_q  <= S_GRAN;
					end
				end
				S_GRAN: begin
					gran_q  <= GW'(alu_y >> GSH);
					state_q <= S_SUM;
				end
				S_SUM: begin
					t_q     <= alu_y;
					foot_q  <= (foot_full > FW'(MaxFoot)) ? '1 : SW'(foot_full);
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (cmd_q == saa_pkg::CMD_ALLOC) begin
						// fits when trailer index lies below the effective limit
						if (borrow) begin
							block_q <= OW'(top_bytes);
							top_q   <= TW'(t_q + AW'(1));
						end else begin
							status_q <= saa_pkg::STATUS_NOMEM;
						end
						state_q <= S_OUT;
					end else if (misaligned || !borrow) begin
						status_q <= saa_pkg::STATUS_NOT_ALLOC;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_TCHK;
					end
				end
				S_TCHK: begin
					if (mem_rdata != UsedCode) begin
						status_q <= saa_pkg::STATUS_NOT_ALLOC;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					state_q <= (top_q == '0) ? S_OUT : S_WEVAL;
				end
				S_WEVAL: begin
					if (mem_rdata == UsedCode) begin
						state_q <= S_OUT;
					end else begin
						// a drop at or past the top clamps to zero
						top_q   <= borrow ? '0 : TW'(alu_y);
						state_q <= S_WALK;
					end
				end
				S_OUT: begin
					if (out_ch.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// APB register
	assign cfg_wr = psel && penable && pwrite && pready &&
		(paddr[saa_pkg::APB_ADDR_W-1:2] == saa_pkg::REG_LIMIT_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= saa_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[SW-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[saa_pkg::APB_ADDR_W-1:2] == saa_pkg::REG_LIMIT_BYTES) ?
		DW'(limit_q) : '0;

	assign in_ch.ready            = (state_q == S_IDLE);
	assign out_ch.valid           = (state_q == S_OUT);
	assign out_ch.status          = status_q;
	assign out_ch.block_offset    = block_q;
	assign out_ch.in_use_bytes    = SW'(top_bytes);
	assign out_ch.footprint_bytes = foot_q;

	`SAA_ASSERT_IMP(a_ready_vs_result, in_ch.ready, !out_ch.valid,
		"input ready while a result is pending")
	`SAA_ASSERT_IMP(a_top_in_arena, 1'b1, top_q <= TW'(ARENA_GRANULES),
		"arena top beyond arena size")
	`SAA_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready,
		!in_ch.ready && !out_ch.valid, "transaction not held for processing")
	`SAA_ASSERT_IMP(a_fail_no_block, out_ch.valid && (out_ch.status != saa_pkg::STATUS_OK),
		out_ch.block_offset == '0, "failed transaction reports a block offset")

endmodule

// ===== hw/rtl/saa_trailer_mem.sv =====
module saa_trailer_mem #(
	parameter int DEPTH  = 4096,
	parameter int DATA_W = 13
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== verif/saa_arena_checker.sv =====
`timescale 1ns / 100ps

module saa_arena_checker #(
	parameter int ARENA_GRANULES = 4096,
	parameter int GRANULE_BYTES  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	saa_in_if                              in_ch,
	saa_out_if                             out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [saa_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [saa_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [saa_pkg::APB_DATA_W-1:0] prdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             pending_count
);

	localparam int SW = saa_pkg::SIZE_W;
	localparam int OW = saa_pkg::OFFSET_W;

	typedef struct packed {
		saa_pkg::status_t      status;
		logic [OW-1:0]         block_offset;
		logic [SW-1:0]         in_use_bytes;
		logic [SW-1:0]         footprint_bytes;
	} arena_reply_t;

	localparam logic [saa_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = {saa_pkg::REG_LIMIT_BYTES, 2'b00};
	localparam logic [31:0]           TRAILER_USED = '1;
	localparam int unsigned           ARENA_BYTES  = ARENA_GRANULES * GRANULE_BYTES;

	logic [SW-1:0]     limit_bytes;
	int unsigned       top_granules;
	logic [31:0]       trailer_store [ARENA_GRANULES];
	arena_reply_t      pending_replies [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want) begin
			report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
		end
	endtask

	// Applies one request to the arena copy and returns the reply it should produce.
	function automatic arena_reply_t arena_step(input logic cmd, input logic [SW-1:0] size,
		input logic [OW-1:0] off);
		int unsigned  gran;
		int unsigned  foot;
		int unsigned  room;
		int unsigned  need;
		int unsigned  trail;
		int unsigned  drop;
		arena_reply_t r;
		gran = size;
		gran = (gran + GRANULE_BYTES - 1) / GRANULE_BYTES;
		foot = (gran + 1) * GRANULE_BYTES;
		r.status = saa_pkg::STATUS_OK;
		r.block_offset = '0;
		if (cmd == saa_pkg::CMD_ALLOC) begin
			room = (limit_bytes < ARENA_BYTES) ? limit_bytes : ARENA_BYTES;
			need = (top_granules + gran + 1) * GRANULE_BYTES;
			if (need > room) begin
				r.status = saa_pkg::STATUS_NOMEM;
			end else begin
				r.block_offset = OW'(top_granules * GRANULE_BYTES);
				trailer_store[(top_granules + gran) % ARENA_GRANULES] = TRAILER_USED;
				top_granules = top_granules + gran + 1;
			end
		end else begin
			trail = off / GRANULE_BYTES + gran;
			if (off % GRANULE_BYTES != 0 || trail >= top_granules ||
				trailer_store[trail % ARENA_GRANULES] != TRAILER_USED) begin
				r.status = saa_pkg::STATUS_NOT_ALLOC;
			end else begin
				trailer_store[trail % ARENA_GRANULES] = gran;
				// pull the top down over freed blocks until a live trailer is met
				while (top_granules > 0 &&
					trailer_store[(top_granules - 1) % ARENA_GRANULES] != TRAILER_USED) begin
					drop = trailer_store[(top_granules - 1) % ARENA_GRANULES] + 1;
					top_granules = (drop >= top_granules) ? 0 : top_granules - drop;
				end
			end
		end
		r.in_use_bytes = SW'(top_granules * GRANULE_BYTES);
		r.footprint_bytes = (foot > 32'hFFFF) ? 16'hFFFF : SW'(foot);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		arena_reply_t want;
		if (!arst_n) begin
			limit_bytes = saa_pkg::LIMIT_RESET;
			top_granules = 0;
			foreach (trailer_store[i]) trailer_store[i] = '0;
			pending_replies.delete();
		end else begin
			if (psel && penable && pready && paddr == LIMIT_ADDR) begin
				if (pwrite) begin
					limit_bytes = pwdata[SW-1:0];
				end else begin
					check_field("limit_bytes read", prdata[SW-1:0], limit_bytes);
				end
			end
			// retire before accepting, so a stray result never pairs with a fresh request
			if (out_ch.valid && out_ch.ready) begin
				if (pending_replies.size() == 0) begin
					report_mismatch($sformatf({"result with no transaction outstanding: ",
						"status %0d offset %0d in_use %0d footprint %0d"}, out_ch.status,
						out_ch.block_offset, out_ch.in_use_bytes, out_ch.footprint_bytes));
				end else begin
					want = pending_replies.pop_front();
					check_field("status", out_ch.status, want.status);
					check_field("block_offset", out_ch.block_offset, want.block_offset);
					check_field("in_use_bytes", out_ch.in_use_bytes, want.in_use_bytes);
					check_field("footprint_bytes", out_ch.footprint_bytes, want.footprint_bytes);
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				pending_replies.push_back(arena_step(in_ch.command, in_ch.size_bytes,
					in_ch.offset_bytes));
			end
		end
		pending_count = pending_replies.size();
	end

endmodule

// ===== verif/tb_stack_arena_allocator_unit.sv =====
`timescale 1ns / 100ps

module tb_stack_arena_allocator_unit;

	localparam int ARENA_GRANULES = 4096;
	localparam int GRANULE_BYTES  = 8;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 81;
	localparam int SW             = saa_pkg::SIZE_W;
	localparam int OW             = saa_pkg::OFFSET_W;
	localparam logic [saa_pkg::APB_ADDR_W-1:0] LIMIT_ADDR = {saa_pkg::REG_LIMIT_BYTES, 2'b00};

	typedef struct {
		int unsigned offset;
		int unsigned size;
	} block_rec_t;

	typedef struct {
		logic        cmd;
		int unsigned size;
	} sent_req_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [saa_pkg::APB_ADDR_W-1:0] paddr;
	logic [saa_pkg::APB_DATA_W-1:0] pwdata;
	logic [saa_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	int                    fail_count;
	int                    pending_count;
	int                    send_idle_pct;
	int                    recv_stall_pct;
	int unsigned           limit_plan [PHASES] = '{32768, 0, 65535, 8, 12, 16384, 0, 1024};
	block_rec_t            live_blocks [$];
	block_rec_t            freed_blocks [$];
	sent_req_t             sent_reqs [$];

	saa_in_if  in_bus ();
	saa_out_if out_bus ();

	stack_arena_allocator_unit #(
		.ARENA_GRANULES (ARENA_GRANULES),
		.GRANULE_BYTES  (GRANULE_BYTES)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_bus),
		.out_ch  (out_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	saa_arena_checker #(
		.ARENA_GRANULES (ARENA_GRANULES),
		.GRANULE_BYTES  (GRANULE_BYTES)
	) arena_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_bus),
		.out_ch        (out_bus),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Keeps a list of granted blocks so that most frees hit a live block.
	always @(posedge clk) begin : track_blocks
		sent_req_t req;
		if (out_bus.valid && out_bus.ready && sent_reqs.size() > 0) begin
			req = sent_reqs.pop_front();
			if (req.cmd == saa_pkg::CMD_ALLOC && out_bus.status == saa_pkg::STATUS_OK) begin
				live_blocks.push_back('{out_bus.block_offset, req.size});
			end
		end
		if (in_bus.valid && in_bus.ready) begin
			sent_reqs.push_back('{in_bus.command, in_bus.size_bytes});
		end
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_item(input logic cmd, input int unsigned size, input int unsigned off);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(negedge clk);
		end
		in_bus.valid        <= 1'b1;
		in_bus.command      <= cmd;
		in_bus.size_bytes   <= SW'(size);
		in_bus.offset_bytes <= OW'(off);
		do @(posedge clk); while (!in_bus.ready);
		@(negedge clk);
	endtask

	task automatic apb_limit(input logic wr, input logic [saa_pkg::APB_DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= LIMIT_ADDR;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_random_item();
		int unsigned kind;
		int unsigned pick;
		int unsigned size;
		int unsigned idx;
		block_rec_t  b;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 99);
		if (pick < 70) size = $urandom_range(0, 64);
		else if (pick < 90) size = $urandom_range(0, 1024);
		else if (pick < 97) size = $urandom_range(0, 32768);
		else size = $urandom_range(0, 65535);
		if (kind >= 45 && kind < 80 && live_blocks.size() > 0) begin
			idx = $urandom_range(0, live_blocks.size() - 1);
			b = live_blocks[idx];
			live_blocks.delete(idx);
			freed_blocks.push_back(b);
			if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
			send_item(saa_pkg::CMD_FREE, b.size, b.offset);
		end else if (kind >= 80 && kind < 85 && live_blocks.size() > 0) begin
			// live offset, wrong size
			b = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
			send_item(saa_pkg::CMD_FREE, size, b.offset);
		end else if (kind >= 85 && kind < 90 && freed_blocks.size() > 0) begin
			b = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
			send_item(saa_pkg::CMD_FREE, b.size, b.offset);
		end else if (kind >= 90 && kind < 95) begin
			send_item(saa_pkg::CMD_FREE, size,
				$urandom_range(0, ARENA_GRANULES - 1) * GRANULE_BYTES + $urandom_range(1, 7));
		end else if (kind >= 95) begin
			send_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
				$urandom_range(0, 32767));
		end else begin
			send_item(saa_pkg::CMD_ALLOC, size, $urandom_range(0, 32767));
		end
	endtask

	initial begin
		#2_000_000;
		$display("stack_arena_allocator_unit verification failed");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		in_bus.valid        = 1'b0;
		in_bus.command      = saa_pkg::CMD_ALLOC;
		in_bus.size_bytes   = '0;
		in_bus.offset_bytes = '0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// reset value of the limit, read while the trailer RAM is being cleared
		apb_limit(1'b0, '0);

		send_item(saa_pkg::CMD_ALLOC, 0, 0);
		send_item(saa_pkg::CMD_ALLOC, 1, 0);
		send_item(saa_pkg::CMD_ALLOC, 8, 0);
		send_item(saa_pkg::CMD_FREE, 8, 4);          // misaligned
		send_item(saa_pkg::CMD_FREE, 1, 8);          // deferred, top stays
		send_item(saa_pkg::CMD_FREE, 1, 8);          // trailer already freed
		send_item(saa_pkg::CMD_FREE, 0, 40);         // trailer at top
		send_item(saa_pkg::CMD_FREE, 8, 24);         // walks over two blocks
		send_item(saa_pkg::CMD_FREE, 0, 0);          // walk reaches zero
		send_item(saa_pkg::CMD_ALLOC, 32768, 0);     // one granule too many
		send_item(saa_pkg::CMD_ALLOC, 32760, 32767); // fills the arena exactly
		send_item(saa_pkg::CMD_ALLOC, 0, 0);
		send_item(saa_pkg::CMD_FREE, 32760, 0);
		send_item(saa_pkg::CMD_ALLOC, 65535, 0);     // footprint saturates
		send_item(saa_pkg::CMD_FREE, 65535, 32767);
		send_item(saa_pkg::CMD_FREE, 0, 32760);
		send_item(saa_pkg::CMD_ALLOC, 9, 0);
		send_item(saa_pkg::CMD_ALLOC, 7, 0);
		send_item(saa_pkg::CMD_FREE, 9, 0);
		send_item(saa_pkg::CMD_FREE, 7, 24);
		in_bus.valid <= 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			wait (pending_count == 0);
			apb_limit(1'b1, (phase == 6) ? $urandom_range(0, 65535) : limit_plan[phase]);
			apb_limit(1'b0, '0);
			case (phase % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct  = 11;
					recv_stall_pct = 11;
				end
			endcase
			@(negedge clk);
			repeat (PHASE_ITEMS) send_random_item();
			in_bus.valid <= 1'b0;
		end

		wait (pending_count == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("stack_arena_allocator_unit verification clean");
		end else begin
			$display("stack_arena_allocator_unit verification failed");
		end
		$finish;
	end

endmodule
